FILE: design/ritoa_pkg.sv
package ritoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 6;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam int DIV_STEP   = 8;
    localparam int DIV_CHUNKS = VALUE_W / DIV_STEP;
    localparam int CHUNK_W    = $clog2(DIV_CHUNKS);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS = 2'd1;

    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h61;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

    function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d > DIGIT_NINE) begin
            res = ASCII_A + CHAR_W'(d) - CHAR_W'(DIGIT_TEN);
        end else begin
            res = ASCII_ZERO + CHAR_W'(d);
        end
        return res;
    endfunction

endpackage

FILE: design/radix_integer_to_ascii_core.sv
// Converts a 32-bit unsigned number to lower-case ASCII digits in radix 2..36
// (register 0, saturated into that range; reset 10), left-padded with '0' up
// to register 1 characters (saturated at MAX_DIGITS; reset 0). Characters leave
// most significant first, one request each, with o_last on the final one.
// Digits come from a divider that retires 8 dividend bits per cycle; the
// digits go onto a row of MAX_DIGITS shift cells working as a stack. Each
// number passes through division, padding and emission in turn. A new number
// is taken once the last character is in the output register. Configuration
// writes are always ready; the user must make them only while idle, which the
// block itself does not enforce.
module radix_integer_to_ascii_core
    import ritoa_pkg::*;
#(
    parameter int MAX_DIGITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_W-1:0]    i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CHAR_W-1:0]     o_ascii_char,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_PAD  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_minlen, n_minlen;
    logic [RADIX_W-1:0]  r_radix;
    logic [RADIX_W-1:0]  r_min_digits;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;

    logic                in_accept;
    logic                out_take;
    logic                load_out;
    logic [CNT_W-1:0]    minlen_sat;
    logic [RADIX_W-1:0]  base;

    logic                div_start;
    logic [VALUE_W-1:0]  div_dividend;
    logic                div_done;
    logic [VALUE_W-1:0]  div_quo;
    logic [DIGIT_W-1:0]  div_rem;

    t_stack_ctl          stk;
    logic [DIGIT_W-1:0]  push_digit;
    logic [DIGIT_W-1:0]  cell_q [MAX_DIGITS];

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign base        = sat_radix(r_radix);

    always_comb begin
        if (int'(r_min_digits) > MAX_DIGITS) begin
            minlen_sat = CNT_W'(MAX_DIGITS);
        end else begin
            minlen_sat = CNT_W'(r_min_digits);
        end
    end

    ritoa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_base     (base),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        logic [DIGIT_W-1:0] shallow;
        logic [DIGIT_W-1:0] deep;

        if (g == 0) begin : g_top
            assign shallow = push_digit;
        end else begin : g_mid
            assign shallow = cell_q[g-1];
        end

        if (g == MAX_DIGITS - 1) begin : g_bottom
            assign deep = '0;
        end else begin : g_above
            assign deep = cell_q[g+1];
        end

        ritoa_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (stk),
            .i_shallow (shallow),
            .i_deep    (deep),
            .o_digit   (cell_q[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_minlen     = r_minlen;
        stk          = '0;
        push_digit   = div_rem;
        div_start    = 1'b0;
        div_dividend = div_quo;
        load_out     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    div_start    = 1'b1;
                    div_dividend = i_value;
                    n_count      = '0;
                    n_minlen     = minlen_sat;
                    n_state      = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    stk.push = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                    if (div_quo == '0) begin
                        n_state = S_PAD;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            S_PAD: begin
                if (r_count < r_minlen) begin
                    stk.push   = 1'b1;
                    push_digit = '0;
                    n_count    = r_count + CNT_W'(1);
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    stk.pop  = 1'b1;
                    n_count  = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_minlen     <= '0;
            r_out_valid  <= 1'b0;
            r_radix      <= RADIX_RESET;
            r_min_digits <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_minlen    <= n_minlen;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_RADIX) begin
                    r_radix <= i_cfg_data;
                end else if (i_cfg_index == REG_MIN_DIGITS) begin
                    r_min_digits <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_char <= digit_to_ascii(cell_q[0]);
            r_last <= (r_count == CNT_W'(1));
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ascii_char = r_char;
    assign o_last       = r_last;

endmodule

FILE: design/ritoa_div.sv
module ritoa_div
    import ritoa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VALUE_W-1:0] i_dividend,
    input  logic [RADIX_W-1:0] i_base,
    output logic               o_done,
    output logic [VALUE_W-1:0] o_quo,
    output logic [DIGIT_W-1:0] o_rem
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CHUNK_W-1:0] r_step, n_step;
    logic [VALUE_W-1:0] r_work, n_work;
    logic [DIGIT_W-1:0] r_rem,  n_rem;

    logic [DIGIT_W:0]    rem_acc;
    logic [DIV_STEP-1:0] qbits;

    always_comb begin
        rem_acc = {1'b0, r_rem};
        qbits   = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            rem_acc = {rem_acc[DIGIT_W-1:0], r_work[VALUE_W-1-i]};
            if (rem_acc >= {1'b0, i_base}) begin
                rem_acc = rem_acc - {1'b0, i_base};
                qbits[DIV_STEP-1-i] = 1'b1;
            end
        end

        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_work = r_work;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_work = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_work = {r_work[VALUE_W-DIV_STEP-1:0], qbits};
            n_rem  = rem_acc[DIGIT_W-1:0];
            n_step = r_step + CHUNK_W'(1);
            if (r_step == CHUNK_W'(DIV_CHUNKS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_quo  = r_work;
    assign o_rem  = r_rem;

endmodule

FILE: design/ritoa_cell.sv
module ritoa_cell
    import ritoa_pkg::*;
(
    input  logic               i_clk,
    input  t_stack_ctl         i_ctl,
    input  logic [DIGIT_W-1:0] i_shallow,
    input  logic [DIGIT_W-1:0] i_deep,
    output logic [DIGIT_W-1:0] o_digit
);

    logic [DIGIT_W-1:0] r_digit, n_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.push) begin
            n_digit = i_shallow;
        end else if (i_ctl.pop) begin
            n_digit = i_deep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule
